[rtl/core/sia_pkg.sv]
// Shared types and constants of the spatial information accumulator.
`default_nettype none
package sia_pkg;

   typedef struct packed {
      logic [23:0] occupancy;
      logic [31:0] cell_rate;
      logic        last_cell;
   } sia_req_type;

   typedef struct packed {
      logic signed [31:0] information;
      logic               saturated;
   } sia_rsp_type;

   typedef enum logic [0:0] {
      CSR_MEAN_RATE     = 1'b0,
      CSR_TOTAL_SAMPLES = 1'b1
   } sia_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_R,
      ST_NORM,
      ST_LOG,
      ST_LG,
      ST_MUL1,
      ST_DIV_P,
      ST_MUL2,
      ST_ACC,
      ST_OUT
   } sia_state_type;

   localparam int unsigned SUM_W = 48;
   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFFFFFFFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh800000000000;

endpackage
`default_nettype wire

[rtl/core/sia_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module sia_div
   import sia_pkg::*;
#(
   parameter int unsigned NW = 48
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [31:0]   divisor,
   output logic               done,
   output logic [NW-1:0]      quotient
);
   localparam int unsigned CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [32:0]   rem_sh;
   logic [33:0]   diff;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[31:0], q_ff[NW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, d_ff};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[33] ? rem_sh : diff[32:0];
         q_in   = {q_ff[NW-2:0], ~diff[33]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

[rtl/core/spatial_information_accumulator_core.sv]
// Top level: per-cell Skaggs information term and saturating accumulation.
// Each req transaction carries one map cell (occupancy, cell_rate, last_cell).
// A cell with zero occupancy, zero rate or a rate ratio that truncates to zero
// adds nothing. Other cells add r*log2(r)*p to a 48-bit signed sum, where r is
// cell_rate/mean_rate and p is occupancy/total_samples.
// A cell marked last produces one rsp transaction with the sum in Q16.16,
// clamped with a saturated flag, and clears the sum.
// A full cell runs the bit-serial divider twice, the leading-one shift, one
// squaring per log2 bit and the bit-serial multiplier twice; a cell with
// zero occupancy or zero rate skips the arithmetic, and one whose ratio
// truncates to zero ends after the first division. req_ready is high
// only between cells.
// The result sits in an output register; a stalled receiver holds the next
// result back but not the work on the cells before it.
// Reset clears the sum and loads mean_rate = 1.0 and total_samples = 1.
// The csr port always accepts; write it only while the block is idle.
`default_nettype none
module spatial_information_accumulator_core
   import sia_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned LOG_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sia_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sia_rsp_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int unsigned NW  = 32 + FRAC_BITS;
   localparam int unsigned LZW = $clog2(NW);
   localparam int unsigned PW  = 24 + FRAC_BITS;
   localparam int unsigned LW  = LOG_STEPS + 6;
   localparam int unsigned LGW = LOG_STEPS + 7;
   localparam int unsigned MLW = (LW > PW) ? LW : PW;
   localparam int unsigned MCW = 38 + FRAC_BITS;
   localparam int unsigned AW  = 65 + FRAC_BITS;
   localparam int unsigned CW  = $clog2(MLW + 1);
   localparam int unsigned SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int unsigned SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam logic [AW-1:0] MUL_CAP = AW'(1) << (47 + FRAC_BITS);
   localparam logic signed [55:0] Q_MAX = 56'sh0000007FFFFFFF;
   localparam logic signed [55:0] Q_MIN = 56'shFFFFFF80000000;

   sia_state_type      state_ff, state_in;
   logic [31:0]        mean_rate_ff, total_ff;
   logic [23:0]        occ_ff, occ_in;
   logic               last_ff, last_in;
   logic [NW-1:0]      r_ff, r_in, norm_ff, norm_in;
   logic [LZW-1:0]     lz_ff, lz_in;
   logic [31:0]        m_ff, m_in;
   logic [LOG_STEPS-1:0] frac_ff, frac_in;
   logic               neg_ff, neg_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [MCW-1:0]     mcand_ff, mcand_in;
   logic [MLW-1:0]     mplier_ff, mplier_in;
   logic               msat_ff, msat_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sia_rsp_type        rsp_data_ff, rsp_data_in;

   logic               div_start, div_done;
   logic [NW-1:0]      div_dividend, div_q;
   logic [31:0]        div_divisor, mr_eff, ts_eff;
   logic [63:0]        sq;
   logic [32:0]        sq_sh;
   logic [AW-1:0]      mul_sum;
   logic [LGW-1:0]     int_w, lg_w, lmag_w;
   logic [SUM_W-1:0]   t2;
   logic signed [SUM_W:0] term_w, s_w;
   logic signed [SUM_W-1:0] s_clamp;
   logic signed [55:0] q_w;
   logic signed [31:0] info_w;
   logic               qsat_w;

   assign mr_eff = (mean_rate_ff == '0) ? 32'd1 : mean_rate_ff;
   assign ts_eff = (total_ff == '0) ? 32'd1 : total_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_rate_ff <= 32'd65536;
         total_ff     <= 32'd1;
      end else if (csr_valid) begin
         unique case (sia_csr_type'(csr_index))
            CSR_MEAN_RATE:     mean_rate_ff <= csr_data;
            CSR_TOTAL_SAMPLES: total_ff     <= {8'd0, csr_data[23:0]};
            default:           mean_rate_ff <= mean_rate_ff;
         endcase
      end
   end

   sia_div #(.NW(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      // Shared datapath pieces.
      sq      = 64'(m_ff) * 64'(m_ff);
      sq_sh   = sq[63:31];
      mul_sum = {acc_ff[AW-2:0], 1'b0} + (mplier_ff[MLW-1] ? AW'(mcand_ff) : '0);
      int_w   = LGW'(31) - LGW'(lz_ff);
      lg_w    = (int_w << LOG_STEPS) | LGW'(frac_ff);
      lmag_w  = lg_w[LGW-1] ? (~lg_w + 1'b1) : lg_w;
      t2      = msat_ff ? SUM_MAX : acc_ff[FRAC_BITS +: SUM_W];
      term_w  = neg_ff ? -$signed({1'b0, t2}) : $signed({1'b0, t2});
      s_w     = $signed({sum_ff[SUM_W-1], sum_ff}) + term_w;
      if (s_w[SUM_W] != s_w[SUM_W-1]) begin
         s_clamp = s_w[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         s_clamp = s_w[SUM_W-1:0];
      end
      q_w = ($signed({{8{sum_ff[SUM_W-1]}}, sum_ff}) <<< SHL) >>> SHR;
      if (q_w > Q_MAX) begin
         info_w = Q_MAX[31:0];
         qsat_w = 1'b1;
      end else if (q_w < Q_MIN) begin
         info_w = Q_MIN[31:0];
         qsat_w = 1'b1;
      end else begin
         info_w = q_w[31:0];
         qsat_w = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      last_in      = last_ff;
      r_in         = r_ff;
      norm_in      = norm_ff;
      lz_in        = lz_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      msat_in      = msat_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = {8'd0, occ_ff, {FRAC_BITS{1'b0}}};
      div_divisor  = ts_eff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            div_dividend = {req_data.cell_rate, {FRAC_BITS{1'b0}}};
            div_divisor  = mr_eff;
            if (req_valid) begin
               occ_in  = req_data.occupancy;
               last_in = req_data.last_cell;
               if (req_data.occupancy == '0 || req_data.cell_rate == '0) begin
                  state_in = req_data.last_cell ? ST_OUT : ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_R;
               end
            end
         end
         ST_DIV_R: begin
            if (div_done) begin
               r_in    = div_q;
               norm_in = div_q;
               lz_in   = '0;
               if (div_q == '0) begin
                  state_in = last_ff ? ST_OUT : ST_IDLE;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (norm_ff[NW-1]) begin
               m_in     = norm_ff[NW-1 -: 32];
               frac_in  = '0;
               step_in  = '0;
               state_in = ST_LOG;
            end else begin
               norm_in = {norm_ff[NW-2:0], 1'b0};
               lz_in   = lz_ff + 1'b1;
            end
         end
         ST_LOG: begin
            // Squaring the mantissa doubles its log; a carry past 2.0 is one more bit.
            m_in    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            frac_in = {frac_ff[LOG_STEPS-2:0], sq_sh[32]};
            step_in = step_ff + 1'b1;
            if (step_ff == CW'(LOG_STEPS - 1)) begin
               state_in = ST_LG;
            end
         end
         ST_LG: begin
            neg_in    = lg_w[LGW-1];
            mplier_in = MLW'(lmag_w[LW-1:0]);
            mcand_in  = MCW'(r_ff);
            acc_in    = '0;
            step_in   = '0;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in    = mul_sum;
            mplier_in = {mplier_ff[MLW-2:0], 1'b0};
            step_in   = step_ff + 1'b1;
            if (step_ff == CW'(MLW - 1)) begin
               mcand_in  = mul_sum[LOG_STEPS +: MCW];
               div_start = 1'b1;
               state_in  = ST_DIV_P;
            end
         end
         ST_DIV_P: begin
            if (div_done) begin
               mplier_in = MLW'(div_q[PW-1:0]);
               acc_in    = '0;
               msat_in   = 1'b0;
               step_in   = '0;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            // Once the product reaches the clamp level its exact value no longer matters.
            if (!msat_ff) begin
               acc_in = mul_sum;
               if (mul_sum >= MUL_CAP) begin
                  msat_in = 1'b1;
               end
            end
            mplier_in = {mplier_ff[MLW-2:0], 1'b0};
            step_in   = step_ff + 1'b1;
            if (step_ff == CW'(MLW - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in   = s_clamp;
            state_in = last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.information = info_w;
               rsp_data_in.saturated   = qsat_w;
               sum_in                  = '0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         step_ff      <= '0;
         msat_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         msat_ff      <= msat_in;
      end
      occ_ff      <= occ_in;
      last_ff     <= last_in;
      r_ff        <= r_in;
      norm_ff     <= norm_in;
      lz_ff       <= lz_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NORM |-> norm_ff != '0)
      else $error("leading-one search started on a zero ratio");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_R || state_ff == ST_DIV_P))
      else $error("divider finished outside a wait state");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result loaded outside the output state");

endmodule
`default_nettype wire

[bench/tb_spatial_information_accumulator_core.sv]
// Self-checking bench for the spatial information accumulator core.
`timescale 1ns / 100ps
`default_nettype none
module tb_spatial_information_accumulator_core;
   import sia_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sia_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sia_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   localparam int FRAC = 16;
   localparam int LSTEPS = 16;
   localparam logic signed [63:0] TERM_MAX = 64'sh7FFFFFFFFFFF;
   localparam logic signed [63:0] TERM_MIN = -64'sh800000000000;

   spatial_information_accumulator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Predictor state, tracking the configuration the block holds.
   logic [31:0]        mean_rate_reg;
   logic [23:0]        total_samples_reg;
   logic signed [63:0] info_sum;

   sia_req_type cell_queue[$];
   sia_rsp_type info_queue[$];
   int          errors = 0;
   bit          hold_sender = 1'b0;

   // floor(a*b / 2^s), saturating at all ones.
   function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> s;
      if (prod[127:64] != 0) return '1;
      return prod[63:0];
   endfunction

   function automatic logic signed [63:0] log2_fixed(logic [63:0] x);
      int          top;
      logic [63:0] mant;
      logic [63:0] frac;
      top = 63;
      frac = 0;
      while (top > 0 && x[top] == 1'b0) top--;
      if (top > 31) mant = x >> (top - 31);
      else mant = x << (31 - top);
      for (int i = 0; i < LSTEPS; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            mant = mant >> 1;
            frac[0] = 1'b1;
         end
      end
      return 64'(signed'(top - FRAC)) * (64'sd1 <<< LSTEPS) + signed'(frac);
   endfunction

   task automatic predict_cell(input sia_req_type c);
      logic [63:0]        mr, ts, ratio, prob, lmag, t1, t2;
      logic signed [63:0] lg, term, s;
      sia_rsp_type        o;
      mr = (mean_rate_reg == 0) ? 64'd1 : {32'd0, mean_rate_reg};
      ts = (total_samples_reg == 0) ? 64'd1 : {40'd0, total_samples_reg};
      if (c.occupancy != 0 && c.cell_rate != 0) begin
         ratio = ({32'd0, c.cell_rate} << FRAC) / mr;
         if (ratio != 0) begin
            prob = ({40'd0, c.occupancy} << FRAC) / ts;
            lg = log2_fixed(ratio);
            lmag = (lg < 0) ? -lg : lg;
            t1 = mul_shift_sat(ratio, lmag, LSTEPS);
            t2 = mul_shift_sat(t1, prob, FRAC);
            if (t2 > TERM_MAX) t2 = TERM_MAX;
            term = (lg < 0) ? -signed'(t2) : signed'(t2);
            s = info_sum + term;
            if (s > TERM_MAX) s = TERM_MAX;
            if (s < TERM_MIN) s = TERM_MIN;
            info_sum = s;
         end
      end
      if (c.last_cell) begin
         o.saturated = 1'b0;
         if (info_sum > 64'sh7FFFFFFF) begin
            o.information = 32'h7FFFFFFF;
            o.saturated = 1'b1;
         end else if (info_sum < -64'sh80000000) begin
            o.information = 32'h80000000;
            o.saturated = 1'b1;
         end else begin
            o.information = info_sum[31:0];
         end
         info_queue.push_back(o);
         info_sum = 0;
      end
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_cell(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || hold_sender || cell_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               req_valid <= 1'b1;
               req_data <= cell_queue.pop_front();
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Monitor: the receiver stalls on a pattern that drifts through phases.
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase / 97) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= (stall_phase % 7 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) > 1);
         endcase
         if (rsp_valid && rsp_ready) begin
            if (info_queue.size() == 0) begin
               $display("%0t unexpected transaction: actual info=%h sat=%b", $time,
                  rsp_data.information, rsp_data.saturated);
               errors++;
            end else begin
               sia_rsp_type want;
               want = info_queue.pop_front();
               if (want.information !== rsp_data.information) begin
                  $display("%0t information: expected %h actual %h", $time,
                     want.information, rsp_data.information);
                  errors++;
               end
               if (want.saturated !== rsp_data.saturated) begin
                  $display("%0t saturated: expected %b actual %b", $time,
                     want.saturated, rsp_data.saturated);
                  errors++;
               end
            end
         end
      end
   end

   function automatic sia_req_type make_cell(logic [23:0] occ, logic [31:0] rate, logic last);
      sia_req_type c;
      c.occupancy = occ;
      c.cell_rate = rate;
      c.last_cell = last;
      return c;
   endfunction

   task automatic wait_drained();
      while (cell_queue.size() != 0 || req_valid || info_queue.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input sia_csr_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MEAN_RATE) mean_rate_reg = value;
      else total_samples_reg = value[23:0];
   endtask

   function automatic logic [31:0] rand_rate();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(1, 32'h0003_0000);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      mean_rate_reg = 32'd65536;
      total_samples_reg = 24'd1;
      info_sum = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, extremes, skips, skipped last cell.
      cell_queue.push_back(make_cell(24'd0, 32'h0002_0000, 1'b0));
      cell_queue.push_back(make_cell(24'd5, 32'd0, 1'b0));
      cell_queue.push_back(make_cell(24'd1, 32'h0002_0000, 1'b1));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'hFFFFFFFF, 1'b1));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'h0000_8000, 1'b1));
      cell_queue.push_back(make_cell(24'd0, 32'd0, 1'b1));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'hFFFFFFFF, 1'b0));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'hFFFFFFFF, 1'b0));
      cell_queue.push_back(make_cell(24'd0, 32'd1, 1'b1));
      wait_drained();
      // Zero registers act as one; a rate of one now gives a ratio of 1.0.
      write_reg(CSR_MEAN_RATE, 32'd0);
      write_reg(CSR_TOTAL_SAMPLES, 32'd0);
      cell_queue.push_back(make_cell(24'd3, 32'd1, 1'b0));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'h0000_0001, 1'b1));
      wait_drained();
      write_reg(CSR_MEAN_RATE, 32'hFFFFFFFF);
      write_reg(CSR_TOTAL_SAMPLES, 32'hFFFFFF);
      cell_queue.push_back(make_cell(24'd1, 32'h0000_FFFF, 1'b0));
      cell_queue.push_back(make_cell(24'hFFFFFF, 32'hFFFFFFFF, 1'b1));
      cell_queue.push_back(make_cell(24'hABCDEF, 32'h5555_AAAA, 1'b1));
      wait_drained();

      // Random maps under a sequence of settings.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_reg(CSR_MEAN_RATE, 32'd65536);
            1: write_reg(CSR_MEAN_RATE, 32'd1);
            2: write_reg(CSR_MEAN_RATE, 32'hFFFFFFFF);
            default: write_reg(CSR_MEAN_RATE, $urandom_range(1, 32'h0010_0000));
         endcase
         case (phase)
            1: write_reg(CSR_TOTAL_SAMPLES, 32'd1);
            2: write_reg(CSR_TOTAL_SAMPLES, 32'hFFFFFF);
            default: write_reg(CSR_TOTAL_SAMPLES, $urandom_range(1, 32'hFFFFFF));
         endcase
         for (int i = 0; i < 62; i++) begin
            logic [23:0] occ;
            occ = ($urandom_range(0, 7) == 0) ? 24'd0 :
                  ($urandom_range(0, 3) == 0) ? 24'(~$urandom_range(0, 3)) : 24'($urandom);
            cell_queue.push_back(make_cell(occ, rand_rate(), $urandom_range(0, 5) == 0));
         end
         cell_queue.push_back(make_cell(24'($urandom), rand_rate(), 1'b1));
         if (phase == 4) begin
            // Hold the sender until all pending results have arrived.
            while (cell_queue.size() > 30) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || info_queue.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
